>>> hdl/mres_pkg.sv
// ----------------------------------------------------------------------------
// mres_pkg: shared types and constants of the multi-ring element store
// Sizes of the ring table and the element store, command and status codes,
// and the request bundle sent to the element store.
// ----------------------------------------------------------------------------
package mres_pkg;

    localparam int MAX_CHAINS  = 8;
    localparam int MAX_LEN     = 32;
    localparam int DATA_W      = 64;
    localparam int STORE_DEPTH = MAX_CHAINS * MAX_LEN;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CHAIN_W     = $clog2(MAX_CHAINS);
    localparam int SLOT_W      = $clog2(MAX_LEN);
    localparam int LEN_W       = SLOT_W + 1;
    localparam int COUNT_W     = 4;

    // Remainder unit: dividend is head + position, one bit wider than a slot.
    localparam int SUM_W       = SLOT_W + 1;
    localparam int SHIFT_W     = SUM_W + SUM_W - 1;
    localparam int STEP_W      = $clog2(SUM_W);

    localparam int KIND_W      = 3;
    localparam int STATUS_W    = 2;
    localparam int MAXEL_W     = 6;
    localparam int CFG_IDX_W   = 2;

    // Register reset values.
    localparam logic [MAXEL_W-1:0] MAXEL_RESET = 6'd20;
    localparam logic [COUNT_W-1:0] CHAINS_RESET = 4'd1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ELEMENTS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAIN_COUNT  = 2'd1;

    // Command kinds.
    localparam logic [KIND_W-1:0] KIND_ADD       = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR_ALL = 3'd3;
    localparam logic [KIND_W-1:0] KIND_UPDATE    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_READ      = 3'd5;
    localparam logic [KIND_W-1:0] KIND_COUNT     = 3'd6;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic              write;
        logic              read;
        logic [ADDR_W-1:0] addr;
    } store_req_t;

endpackage

>>> hdl/mres_mod_unit.sv
// ----------------------------------------------------------------------------
// mres_mod_unit: iterative remainder unit
// Reduces a small dividend modulo the ring length, one shifted compare and
// subtract per cycle, from the highest shift down to zero.
// ----------------------------------------------------------------------------
module mres_mod_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [mres_pkg::SUM_W-1:0]    dividend,
    input  logic [mres_pkg::LEN_W-1:0]    divisor,
    output logic                          done,
    output logic [mres_pkg::SLOT_W-1:0]   remainder
);

    logic [mres_pkg::SUM_W-1:0]   rem_reg, rem_next;
    logic [mres_pkg::STEP_W-1:0]  step_reg, step_next;
    logic                         run_reg, run_next;
    logic                         done_reg, done_next;
    logic [mres_pkg::SHIFT_W-1:0] trial;
    logic [mres_pkg::SHIFT_W-1:0] rem_wide;

    assign trial    = {{(mres_pkg::SHIFT_W-mres_pkg::LEN_W){1'b0}}, divisor} << step_reg;
    assign rem_wide = {{(mres_pkg::SHIFT_W-mres_pkg::SUM_W){1'b0}}, rem_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        step_next = step_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = dividend;
            step_next = mres_pkg::STEP_W'(mres_pkg::SUM_W - 1);
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            // subtract the shifted divisor wherever it fits
            if (rem_wide >= trial)
            begin
                rem_next = rem_reg - trial[mres_pkg::SUM_W-1:0];
            end
            if (step_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg[mres_pkg::SLOT_W-1:0];

endmodule

>>> hdl/mres_store.sv
// ----------------------------------------------------------------------------
// mres_store: shared element store
// Single-port payload memory with registered read data. Per-entry valid
// bits, cleared at reset, make unwritten entries read as zero.
// ----------------------------------------------------------------------------
module mres_store
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  mres_pkg::store_req_t         req,
    input  logic [mres_pkg::DATA_W-1:0]  wdata,
    output logic [mres_pkg::DATA_W-1:0]  rdata
);

    logic [mres_pkg::DATA_W-1:0] mem [mres_pkg::STORE_DEPTH];
    logic [mres_pkg::STORE_DEPTH-1:0] entry_valid_reg;
    logic [mres_pkg::DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.write)
        begin
            mem[req.addr] <= wdata;
        end
        if (req.read)
        begin
            rdata_reg <= entry_valid_reg[req.addr] ? mem[req.addr] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
        end
        else if (req.write)
        begin
            entry_valid_reg[req.addr] <= 1'b1;
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/multi_ring_element_store_unit.sv
// ----------------------------------------------------------------------------
// multi_ring_element_store_unit: rings of payload words in one shared store
// Keeps up to eight rings, each max_elements slots long, in one element
// store. Add pushes at a head that walks backwards and drops the oldest
// entry when full; remove drops the tail; clear and clear-all empty rings;
// update and read address slot (head + position) mod length. Every
// command returns a status and the addressed ring's element count.
//
//   channel   ports                                      handshake
//   -------   -----------------------------------------  ----------------------
//   command   kind, chain, position, entry_data           start high, busy low
//   result    status, read_data, element_count            done, one-cycle strobe
//   config    cfg_index, cfg_data                          cfg_write
//
// Steps: remove, clear, count, clear-all and out-of-range go exec to done;
// add accesses the store first; live update and read access it after the
// remainder unit reduces head + position, one shifted subtract a cycle.
// Reset: rings empty, max_elements 20, chain_count 1, store reads as zero.
// busy stays high from the accept edge until the cycle of the done strobe;
// the next transaction may start in that same cycle. Results cannot stall.
// ----------------------------------------------------------------------------
module multi_ring_element_store_unit
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [mres_pkg::KIND_W-1:0]      kind,
    input  logic [mres_pkg::CHAIN_W-1:0]     chain,
    input  logic [mres_pkg::SLOT_W-1:0]      position,
    input  logic [mres_pkg::DATA_W-1:0]      entry_data,
    output logic                             done,
    output logic [mres_pkg::STATUS_W-1:0]    status,
    output logic [mres_pkg::DATA_W-1:0]      read_data,
    output logic [mres_pkg::LEN_W-1:0]       element_count,
    input  logic                             cfg_write,
    input  logic [mres_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mres_pkg::MAXEL_W-1:0]     cfg_data
);

    // Sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_MOD    = 3'd2;
    localparam logic [2:0] S_ACCESS = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0] state_reg, state_next;

    // Configuration registers
    logic [mres_pkg::MAXEL_W-1:0] max_elements_reg;
    logic [mres_pkg::COUNT_W-1:0] chain_count_reg;

    // Ring table
    logic                          ring_valid_reg [mres_pkg::MAX_CHAINS];
    logic [mres_pkg::SLOT_W-1:0]   head_reg [mres_pkg::MAX_CHAINS];
    logic [mres_pkg::SLOT_W-1:0]   tail_reg [mres_pkg::MAX_CHAINS];

    // Latched transaction
    logic [mres_pkg::KIND_W-1:0]   cmd_kind_reg;
    logic [mres_pkg::CHAIN_W-1:0]  cmd_chain_reg;
    logic [mres_pkg::SLOT_W-1:0]   cmd_pos_reg;
    logic [mres_pkg::DATA_W-1:0]   cmd_data_reg;
    logic [mres_pkg::STATUS_W-1:0] cmd_status_reg;
    logic [mres_pkg::ADDR_W-1:0]   base_reg;
    logic [mres_pkg::SLOT_W-1:0]   slot_reg;

    // Result registers
    logic                          done_reg;
    logic [mres_pkg::STATUS_W-1:0] status_reg;
    logic [mres_pkg::DATA_W-1:0]   read_data_reg;
    logic [mres_pkg::LEN_W-1:0]    element_count_reg;

    // Derived values
    logic [mres_pkg::LEN_W-1:0]    ring_len;
    logic [mres_pkg::SLOT_W-1:0]   len_m1;
    logic [mres_pkg::COUNT_W-1:0]  rings_used;
    logic                          in_range;
    logic                          cur_valid;
    logic [mres_pkg::SLOT_W-1:0]   cur_head;
    logic [mres_pkg::SLOT_W-1:0]   cur_tail;
    logic [mres_pkg::LEN_W:0]      count_wide;
    logic [mres_pkg::LEN_W-1:0]    ring_count;
    logic [mres_pkg::LEN_W+mres_pkg::CHAIN_W-1:0] base_prod;

    // Command evaluation
    logic [mres_pkg::STATUS_W-1:0] exec_status;
    logic                          ring_we;
    logic                          clear_all;
    logic                          need_mod;
    logic                          new_valid;
    logic [mres_pkg::SLOT_W-1:0]   new_head;
    logic [mres_pkg::SLOT_W-1:0]   new_tail;
    logic                          in_exec;
    logic                          accept;

    // Remainder unit and store
    logic                          mod_start;
    logic                          mod_done;
    logic [mres_pkg::SLOT_W-1:0]   mod_rem;
    logic [mres_pkg::SUM_W-1:0]    mod_dividend;
    mres_pkg::store_req_t          store_req;
    logic [mres_pkg::DATA_W-1:0]   store_rdata;

    function automatic logic [mres_pkg::SLOT_W-1:0] step_back
    (
        input logic [mres_pkg::SLOT_W-1:0] s,
        input logic [mres_pkg::SLOT_W-1:0] last
    );
        return (s == '0) ? last : s - 1'b1;
    endfunction

    assign accept  = start && (state_reg == S_IDLE);
    assign in_exec = (state_reg == S_EXEC);

    // Clamp the ring length to 1..MAX_LEN and the ring count to MAX_CHAINS.
    always_comb
    begin
        if (max_elements_reg == '0)
        begin
            ring_len = mres_pkg::LEN_W'(1);
        end
        else if (max_elements_reg > mres_pkg::MAXEL_W'(mres_pkg::MAX_LEN))
        begin
            ring_len = mres_pkg::LEN_W'(mres_pkg::MAX_LEN);
        end
        else
        begin
            ring_len = max_elements_reg[mres_pkg::LEN_W-1:0];
        end
    end

    assign len_m1     = mres_pkg::SLOT_W'(ring_len - 1'b1);
    assign rings_used = (chain_count_reg > mres_pkg::COUNT_W'(mres_pkg::MAX_CHAINS))
                      ? mres_pkg::COUNT_W'(mres_pkg::MAX_CHAINS) : chain_count_reg;
    assign in_range   = {1'b0, cmd_chain_reg} < rings_used;

    assign cur_valid = ring_valid_reg[cmd_chain_reg];
    assign cur_head  = head_reg[cmd_chain_reg];
    assign cur_tail  = tail_reg[cmd_chain_reg];

    // Count with wrap: tail below head means the ring runs past slot zero.
    always_comb
    begin
        if (cur_tail >= cur_head)
        begin
            count_wide = (mres_pkg::LEN_W+1)'(cur_tail) - (mres_pkg::LEN_W+1)'(cur_head)
                       + 1'b1;
        end
        else
        begin
            count_wide = (mres_pkg::LEN_W+1)'(cur_tail) + (mres_pkg::LEN_W+1)'(ring_len)
                       - (mres_pkg::LEN_W+1)'(cur_head) + 1'b1;
        end
    end

    assign ring_count = cur_valid ? count_wide[mres_pkg::LEN_W-1:0] : '0;
    assign base_prod  = cmd_chain_reg * ring_len;

    // Decide the effect of the latched command on the addressed ring.
    always_comb
    begin
        exec_status = mres_pkg::ST_OK;
        ring_we     = 1'b0;
        clear_all   = 1'b0;
        need_mod    = 1'b0;
        new_valid   = cur_valid;
        new_head    = cur_head;
        new_tail    = cur_tail;
        if (cmd_kind_reg == mres_pkg::KIND_CLEAR_ALL)
        begin
            clear_all = 1'b1;
        end
        else if (!in_range)
        begin
            exec_status = mres_pkg::ST_RANGE;
        end
        else
        begin
            case (cmd_kind_reg)
                mres_pkg::KIND_ADD:
                begin
                    ring_we = 1'b1;
                    if (!cur_valid)
                    begin
                        new_valid = 1'b1;
                        new_head  = len_m1;
                        new_tail  = len_m1;
                    end
                    else
                    begin
                        // step the head back; drop the oldest entry on collision
                        new_head = step_back(cur_head, len_m1);
                        if (new_head == cur_tail)
                        begin
                            new_tail = step_back(cur_tail, len_m1);
                        end
                    end
                end
                mres_pkg::KIND_REMOVE:
                begin
                    if (!cur_valid)
                    begin
                        exec_status = mres_pkg::ST_EMPTY;
                    end
                    else if (cur_tail == cur_head)
                    begin
                        ring_we   = 1'b1;
                        new_valid = 1'b0;
                        new_head  = '0;
                        new_tail  = '0;
                    end
                    else
                    begin
                        ring_we  = 1'b1;
                        new_tail = step_back(cur_tail, len_m1);
                    end
                end
                mres_pkg::KIND_CLEAR:
                begin
                    ring_we   = 1'b1;
                    new_valid = 1'b0;
                    new_head  = '0;
                    new_tail  = '0;
                end
                mres_pkg::KIND_UPDATE, mres_pkg::KIND_READ:
                begin
                    if (!cur_valid)
                    begin
                        exec_status = mres_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        need_mod = 1'b1;
                    end
                end
                default:
                begin
                    // count, and the unused kind that acts as count
                end
            endcase
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (need_mod)
                begin
                    state_next = S_MOD;
                end
                else if ((cmd_kind_reg == mres_pkg::KIND_ADD) && ring_we)
                begin
                    state_next = S_ACCESS;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_MOD:
            begin
                if (mod_done)
                begin
                    state_next = S_ACCESS;
                end
            end
            S_ACCESS:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_DONE);
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_elements_reg <= mres_pkg::MAXEL_RESET;
            chain_count_reg  <= mres_pkg::CHAINS_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == mres_pkg::CFG_MAX_ELEMENTS)
            begin
                max_elements_reg <= cfg_data;
            end
            else if (cfg_index == mres_pkg::CFG_CHAIN_COUNT)
            begin
                chain_count_reg <= cfg_data[mres_pkg::COUNT_W-1:0];
            end
        end
    end

    // Ring table: a valid register write or clear-all empties every ring.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mres_pkg::MAX_CHAINS; i++)
            begin
                ring_valid_reg[i] <= 1'b0;
                head_reg[i]       <= '0;
                tail_reg[i]       <= '0;
            end
        end
        else if ((cfg_write && ((cfg_index == mres_pkg::CFG_MAX_ELEMENTS) ||
                                (cfg_index == mres_pkg::CFG_CHAIN_COUNT))) ||
                 (in_exec && clear_all))
        begin
            for (int i = 0; i < mres_pkg::MAX_CHAINS; i++)
            begin
                ring_valid_reg[i] <= 1'b0;
                head_reg[i]       <= '0;
                tail_reg[i]       <= '0;
            end
        end
        else if (in_exec && ring_we)
        begin
            ring_valid_reg[cmd_chain_reg] <= new_valid;
            head_reg[cmd_chain_reg]       <= new_head;
            tail_reg[cmd_chain_reg]       <= new_tail;
        end
    end

    // Latch the transaction and track its status and slot.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_kind_reg  <= kind;
            cmd_chain_reg <= chain;
            cmd_pos_reg   <= position;
            cmd_data_reg  <= entry_data;
        end
        if (in_exec)
        begin
            cmd_status_reg <= exec_status;
            base_reg       <= base_prod[mres_pkg::ADDR_W-1:0];
            slot_reg       <= new_head;
        end
        if ((state_reg == S_MOD) && mod_done)
        begin
            slot_reg <= mod_rem;
        end
    end

    // Remainder of head + position over the ring length
    assign mod_start    = in_exec && need_mod;
    assign mod_dividend = {1'b0, cur_head} + {1'b0, cmd_pos_reg};

    mres_mod_unit u_mod
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (mod_dividend),
        .divisor   (ring_len),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    // One store access per add, update or read
    always_comb
    begin
        store_req.write = (state_reg == S_ACCESS) && (cmd_kind_reg != mres_pkg::KIND_READ);
        store_req.read  = (state_reg == S_ACCESS) && (cmd_kind_reg == mres_pkg::KIND_READ);
        store_req.addr  = base_reg + mres_pkg::ADDR_W'(slot_reg);
    end

    mres_store u_store
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (store_req),
        .wdata (cmd_data_reg),
        .rdata (store_rdata)
    );

    // Build the result; hold it on the ports for the strobe cycle.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE)
        begin
            status_reg        <= cmd_status_reg;
            element_count_reg <= (cmd_status_reg == mres_pkg::ST_RANGE) ? '0 : ring_count;
            read_data_reg     <= ((cmd_kind_reg == mres_pkg::KIND_READ) &&
                                  (cmd_status_reg == mres_pkg::ST_OK)) ? store_rdata : '0;
        end
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign status        = status_reg;
    assign read_data     = read_data_reg;
    assign element_count = element_count_reg;

    // Assertions
    a_done_after_final: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == S_DONE))
        else $error("result strobe without a finishing step");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("busy not raised after an accepted transaction");

    a_mod_only_in_mod: assert property (@(posedge clk) disable iff (!rst_n)
        mod_done |-> (state_reg == S_MOD))
        else $error("remainder unit finished outside its wait state");

    a_range_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (status_reg != mres_pkg::ST_OK)) |->
            ((read_data_reg == '0) && ((status_reg == mres_pkg::ST_EMPTY) ||
                                       (element_count_reg == '0))))
        else $error("error result carries data or a count");

    a_store_access_once: assert property (@(posedge clk) disable iff (!rst_n)
        (store_req.write || store_req.read) |=> (state_reg == S_DONE))
        else $error("store access not followed by the result step");

endmodule

>>> tb/tb_multi_ring_element_store_unit.sv
// ----------------------------------------------------------------------------
// tb_multi_ring_element_store_unit: self-checking bench of the ring store
// Walks a short table of directed commands and register writes, then runs
// random phases under several register settings. Every accepted command is
// mirrored in a local model of the rings and the shared store, and each
// done strobe is compared field by field with the oldest awaited result.
// ----------------------------------------------------------------------------
module tb_multi_ring_element_store_unit;

    // Kind seven has no name in the package; it behaves as count.
    localparam logic [mres_pkg::KIND_W-1:0] KIND_SPARE = 3'd7;

    // Register indexes beyond the two real registers; writes to them are no-ops.
    localparam logic [mres_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [mres_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 16;
    localparam int REPORT_MAX   = 10;
    localparam int PHASE_ITEMS  = 185;

    // Gap styles: none at all, short only, or short with a few long ones.
    typedef enum int { GAPS_NONE, GAPS_SHORT, GAPS_MIXED } gap_style_t;

    typedef struct packed {
        logic [mres_pkg::STATUS_W-1:0] status;
        logic [mres_pkg::DATA_W-1:0]   read_data;
        logic [mres_pkg::LEN_W-1:0]    count;
    } ring_result_t;

    typedef struct {
        bit                             is_reg;
        logic [mres_pkg::CFG_IDX_W-1:0] reg_index;
        logic [mres_pkg::MAXEL_W-1:0]   reg_value;
        logic [mres_pkg::KIND_W-1:0]    cmd_kind;
        logic [mres_pkg::CHAIN_W-1:0]   cmd_chain;
        logic [mres_pkg::SLOT_W-1:0]    cmd_pos;
        logic [mres_pkg::DATA_W-1:0]    cmd_data;
        bit                             typed;
        ring_result_t                   want;
    } plan_row_t;

    // ------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------
    logic                           clk        = 1'b0;
    logic                           rst_n      = 1'b0;
    logic                           start      = 1'b0;
    logic                           busy;
    logic [mres_pkg::KIND_W-1:0]    kind       = '0;
    logic [mres_pkg::CHAIN_W-1:0]   chain      = '0;
    logic [mres_pkg::SLOT_W-1:0]    position   = '0;
    logic [mres_pkg::DATA_W-1:0]    entry_data = '0;
    logic                           done;
    logic [mres_pkg::STATUS_W-1:0]  status;
    logic [mres_pkg::DATA_W-1:0]    read_data;
    logic [mres_pkg::LEN_W-1:0]     element_count;
    logic                           cfg_write  = 1'b0;
    logic [mres_pkg::CFG_IDX_W-1:0] cfg_index  = '0;
    logic [mres_pkg::MAXEL_W-1:0]   cfg_data   = '0;

    multi_ring_element_store_unit u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .kind          (kind),
        .chain         (chain),
        .position      (position),
        .entry_data    (entry_data),
        .done          (done),
        .status        (status),
        .read_data     (read_data),
        .element_count (element_count),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Local copy of the ring table, the store and the two registers
    // ------------------------------------------------------------------
    logic [mres_pkg::MAXEL_W-1:0] mirror_max_elements;
    logic [mres_pkg::COUNT_W-1:0] mirror_chain_count;
    bit                           ring_live [mres_pkg::MAX_CHAINS];
    int unsigned                  head_pos  [mres_pkg::MAX_CHAINS];
    int unsigned                  tail_pos  [mres_pkg::MAX_CHAINS];
    logic [mres_pkg::DATA_W-1:0]  slot_word [mres_pkg::STORE_DEPTH];

    // Results predicted for accepted transactions, oldest first.
    ring_result_t       awaited_results [$];
    plan_row_t          test_plan [$];

    gap_style_t gap_style    = GAPS_MIXED;
    int         mismatches   = 0;
    int         results_seen = 0;
    int         commands_run = 0;
    int         settings_run = 0;
    int         kind_tally [8];
    int         cycle_count  = 0;

    // ------------------------------------------------------------------
    // Ring arithmetic
    // ------------------------------------------------------------------
    function automatic int unsigned ring_length();
        int unsigned n;
        n = int'(mirror_max_elements);
        if (n < 1)
            n = 1;
        if (n > mres_pkg::MAX_LEN)
            n = mres_pkg::MAX_LEN;
        return n;
    endfunction

    function automatic int unsigned rings_in_use();
        return (mirror_chain_count > mres_pkg::MAX_CHAINS) ? mres_pkg::MAX_CHAINS
                                                           : int'(mirror_chain_count);
    endfunction

    function automatic int unsigned step_back(int unsigned s);
        return (s == 0) ? ring_length() - 1 : s - 1;
    endfunction

    function automatic int unsigned ring_entries(int unsigned c);
        if (!ring_live[c])
            return 0;
        if (tail_pos[c] >= head_pos[c])
            return tail_pos[c] - head_pos[c] + 1;
        return tail_pos[c] + ring_length() - head_pos[c] + 1;
    endfunction

    function automatic int unsigned slot_addr(int unsigned c, int unsigned pos);
        int unsigned len;
        len = ring_length();
        return (c * len + (head_pos[c] + pos) % len) % mres_pkg::STORE_DEPTH;
    endfunction

    function automatic void drop_all_rings();
        for (int i = 0; i < mres_pkg::MAX_CHAINS; i++)
        begin
            ring_live[i] = 1'b0;
            head_pos[i]  = 0;
            tail_pos[i]  = 0;
        end
    endfunction

    function automatic void drop_ring(int unsigned c);
        ring_live[c] = 1'b0;
        head_pos[c]  = 0;
        tail_pos[c]  = 0;
    endfunction

    // Apply one command to the local rings and return what the block should report.
    function automatic ring_result_t compute_ring_result(
        logic [mres_pkg::KIND_W-1:0]  k,
        logic [mres_pkg::CHAIN_W-1:0] ch,
        logic [mres_pkg::SLOT_W-1:0]  pos,
        logic [mres_pkg::DATA_W-1:0]  data);
        ring_result_t r;
        int unsigned  c;
        r.status    = mres_pkg::ST_OK;
        r.read_data = '0;
        r.count     = '0;
        c = int'(ch);
        if (k == mres_pkg::KIND_CLEAR_ALL)
            drop_all_rings();
        else if (c >= rings_in_use())
            r.status = mres_pkg::ST_RANGE;
        else
        begin
            case (k)
                mres_pkg::KIND_ADD:
                begin
                    if (!ring_live[c])
                    begin
                        ring_live[c] = 1'b1;
                        tail_pos[c]  = ring_length() - 1;
                        head_pos[c]  = tail_pos[c];
                    end
                    else
                    begin
                        // Head walks backwards; on meeting the tail, drop the oldest.
                        head_pos[c] = step_back(head_pos[c]);
                        if (head_pos[c] == tail_pos[c])
                            tail_pos[c] = step_back(tail_pos[c]);
                    end
                    slot_word[slot_addr(c, 0)] = data;
                end
                mres_pkg::KIND_REMOVE:
                begin
                    if (!ring_live[c])
                        r.status = mres_pkg::ST_EMPTY;
                    else if (tail_pos[c] == head_pos[c])
                        drop_ring(c);
                    else
                        tail_pos[c] = step_back(tail_pos[c]);
                end
                mres_pkg::KIND_CLEAR:
                    drop_ring(c);
                mres_pkg::KIND_UPDATE:
                begin
                    if (!ring_live[c])
                        r.status = mres_pkg::ST_EMPTY;
                    else
                        slot_word[slot_addr(c, pos)] = data;
                end
                mres_pkg::KIND_READ:
                begin
                    if (!ring_live[c])
                        r.status = mres_pkg::ST_EMPTY;
                    else
                        r.read_data = slot_word[slot_addr(c, pos)];
                end
                default: ;
            endcase
            r.count = mres_pkg::LEN_W'(ring_entries(c));
        end
        return r;
    endfunction

    function automatic void mirror_register(logic [mres_pkg::CFG_IDX_W-1:0] idx,
                                            logic [mres_pkg::MAXEL_W-1:0] val);
        if (idx == mres_pkg::CFG_MAX_ELEMENTS)
        begin
            mirror_max_elements = val;
            drop_all_rings();
        end
        else if (idx == mres_pkg::CFG_CHAIN_COUNT)
        begin
            mirror_chain_count = val[mres_pkg::COUNT_W-1:0];
            drop_all_rings();
        end
    endfunction

    // ------------------------------------------------------------------
    // Directed plan builders
    // ------------------------------------------------------------------
    function automatic void plan_command(logic [mres_pkg::KIND_W-1:0] k,
                                         logic [mres_pkg::CHAIN_W-1:0] ch,
                                         logic [mres_pkg::SLOT_W-1:0] pos,
                                         logic [mres_pkg::DATA_W-1:0] data,
                                         bit typed,
                                         logic [mres_pkg::STATUS_W-1:0] st,
                                         logic [mres_pkg::DATA_W-1:0] rd,
                                         logic [mres_pkg::LEN_W-1:0] cnt);
        plan_row_t row;
        row.is_reg         = 1'b0;
        row.reg_index      = '0;
        row.reg_value      = '0;
        row.cmd_kind       = k;
        row.cmd_chain      = ch;
        row.cmd_pos        = pos;
        row.cmd_data       = data;
        row.typed          = typed;
        row.want.status    = st;
        row.want.read_data = rd;
        row.want.count     = cnt;
        test_plan.push_back(row);
    endfunction

    function automatic void plan_register(logic [mres_pkg::CFG_IDX_W-1:0] idx,
                                          logic [mres_pkg::MAXEL_W-1:0] val);
        plan_row_t row;
        row           = '{default: '0};
        row.is_reg    = 1'b1;
        row.reg_index = idx;
        row.reg_value = val;
        test_plan.push_back(row);
    endfunction

    // Mostly short gaps, now and then a long one; none in a quiet stretch.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (gap_style == GAPS_NONE)
            return 0;
        roll = $urandom_range(99);
        if (roll < 45)
            return 0;
        if (roll < 85 || gap_style == GAPS_SHORT)
            return $urandom_range(1, 4);
        if (roll < 96)
            return $urandom_range(5, 14);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Present one command, hold it until accepted, then record its result.
    task automatic issue_command(logic [mres_pkg::KIND_W-1:0] k,
                                 logic [mres_pkg::CHAIN_W-1:0] ch,
                                 logic [mres_pkg::SLOT_W-1:0] pos,
                                 logic [mres_pkg::DATA_W-1:0] data,
                                 bit typed, ring_result_t want);
        int unsigned  gap;
        ring_result_t predicted;
        gap = pick_gap();
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        kind       <= k;
        chain      <= ch;
        position   <= pos;
        entry_data <= data;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        // Accepted at this edge; start stays up in case the next one follows at once.
        predicted = compute_ring_result(k, ch, pos, data);
        awaited_results.push_back(typed ? want : predicted);
        commands_run++;
        kind_tally[k]++;
    endtask

    // Drop start, let every outstanding transaction finish, then pad a few cycles.
    task automatic quiesce();
        start <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic [mres_pkg::CFG_IDX_W-1:0] idx,
                                  logic [mres_pkg::MAXEL_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        mirror_register(idx, val);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // Random command shaped toward live rings: mostly adds and reads at valid chains.
    task automatic issue_random_command();
        logic [mres_pkg::KIND_W-1:0]  k;
        logic [mres_pkg::CHAIN_W-1:0] ch;
        logic [mres_pkg::SLOT_W-1:0]  pos;
        logic [mres_pkg::DATA_W-1:0]  data;
        int unsigned                  roll;
        int unsigned                  depth;
        ring_result_t                 unused;
        roll = $urandom_range(99);
        if (roll < 35)
            k = mres_pkg::KIND_ADD;
        else if (roll < 53)
            k = mres_pkg::KIND_READ;
        else if (roll < 67)
            k = mres_pkg::KIND_UPDATE;
        else if (roll < 80)
            k = mres_pkg::KIND_REMOVE;
        else if (roll < 88)
            k = mres_pkg::KIND_COUNT;
        else if (roll < 93)
            k = mres_pkg::KIND_CLEAR;
        else if (roll < 95)
            k = mres_pkg::KIND_CLEAR_ALL;
        else
            k = KIND_SPARE;

        if (rings_in_use() != 0 && $urandom_range(9) != 0)
            ch = mres_pkg::CHAIN_W'($urandom_range(rings_in_use() - 1));
        else
            ch = mres_pkg::CHAIN_W'($urandom_range(mres_pkg::MAX_CHAINS - 1));

        // Aim positions inside the filled part of the ring most of the time.
        depth = (ch < rings_in_use()) ? ring_entries(ch) : 0;
        if (depth != 0 && $urandom_range(9) < 7)
            pos = mres_pkg::SLOT_W'($urandom_range(depth - 1));
        else
            pos = mres_pkg::SLOT_W'($urandom_range(mres_pkg::MAX_LEN - 1));

        roll = $urandom_range(15);
        if (roll == 0)
            data = '1;
        else if (roll == 1)
            data = '0;
        else
            data = {$urandom, $urandom};

        unused = '0;
        issue_command(k, ch, pos, data, 1'b0, unused);
    endtask

    // Quiesce, then move to a new register setting and run one random phase.
    task automatic run_phase(logic [mres_pkg::MAXEL_W-1:0] max_el,
                             logic [mres_pkg::MAXEL_W-1:0] chains,
                             int items, gap_style_t style);
        quiesce();
        write_register(mres_pkg::CFG_MAX_ELEMENTS, max_el);
        write_register(mres_pkg::CFG_CHAIN_COUNT, chains);
        settings_run++;
        gap_style = style;
        repeat (items) issue_random_command();
    endtask

    // ------------------------------------------------------------------
    // Result checker: compare every done strobe with the oldest expectation
    // ------------------------------------------------------------------
    function automatic void report_mismatch(string field,
                                            logic [mres_pkg::DATA_W-1:0] exp_v,
                                            logic [mres_pkg::DATA_W-1:0] act_v);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("[%0d] %s mismatch: expected 0x%0h, got 0x%0h",
                     cycle_count, field, exp_v, act_v);
    endfunction

    always @(posedge clk)
    begin : check_results
        ring_result_t want;
        if (rst_n && done)
        begin
            results_seen++;
            if (awaited_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("[%0d] result with no transaction outstanding: status %0d",
                             cycle_count, status);
            end
            else
            begin
                want = awaited_results.pop_front();
                if (status !== want.status)
                    report_mismatch("status", want.status, status);
                if (read_data !== want.read_data)
                    report_mismatch("read_data", want.read_data, read_data);
                if (element_count !== want.count)
                    report_mismatch("element_count", want.count, element_count);
            end
        end
    end

    // Hard stop if the block hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, awaited_results.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        // Mirror the reset state: empty rings, zeroed store, reset registers.
        mirror_max_elements = mres_pkg::MAXEL_RESET;
        mirror_chain_count  = mres_pkg::CHAINS_RESET;
        drop_all_rings();
        for (int i = 0; i < mres_pkg::STORE_DEPTH; i++)
            slot_word[i] = '0;
        for (int i = 0; i < 8; i++)
            kind_tally[i] = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed plan, starting from reset values: 20 slots, one ring.
        plan_command(mres_pkg::KIND_COUNT,  3'd0, 5'd0, '0,
                     1'b1, mres_pkg::ST_OK,    '0, 6'd0);
        plan_command(mres_pkg::KIND_READ,   3'd0, 5'd0, '0,
                     1'b1, mres_pkg::ST_EMPTY, '0, 6'd0);
        plan_command(mres_pkg::KIND_REMOVE, 3'd0, 5'd0, '0,
                     1'b1, mres_pkg::ST_EMPTY, '0, 6'd0);
        plan_command(mres_pkg::KIND_UPDATE, 3'd0, 5'd5, 64'h1234_5678_9ABC_DEF0,
                     1'b1, mres_pkg::ST_EMPTY, '0, 6'd0);
        // Chains past chain_count are out of range for every kind but clear-all.
        plan_command(mres_pkg::KIND_ADD,    3'd1, 5'd0, '1,
                     1'b1, mres_pkg::ST_RANGE, '0, 6'd0);
        plan_command(mres_pkg::KIND_READ,   3'd7, 5'd31, '0,
                     1'b1, mres_pkg::ST_RANGE, '0, 6'd0);
        plan_command(mres_pkg::KIND_ADD,    3'd0, 5'd0, '1,
                     1'b1, mres_pkg::ST_OK,    '0, 6'd1);
        plan_command(mres_pkg::KIND_READ,   3'd0, 5'd0, '0,
                     1'b1, mres_pkg::ST_OK,    '1, 6'd1);
        plan_command(mres_pkg::KIND_ADD,    3'd0, 5'd0, '0,
                     1'b1, mres_pkg::ST_OK,    '0, 6'd2);
        plan_command(mres_pkg::KIND_READ,   3'd0, 5'd31, '0,
                     1'b0, mres_pkg::ST_OK,    '0, 6'd0);
        plan_command(mres_pkg::KIND_UPDATE, 3'd0, 5'd1, 64'hA5A5_5A5A_F00F_0FF0,
                     1'b0, mres_pkg::ST_OK,    '0, 6'd0);
        plan_command(mres_pkg::KIND_READ,   3'd0, 5'd1, '0,
                     1'b0, mres_pkg::ST_OK,    '0, 6'd0);
        // Kind seven falls through to count.
        plan_command(KIND_SPARE,            3'd0, 5'd0, '0,
                     1'b1, mres_pkg::ST_OK,    '0, 6'd2);
        // Clear-all ignores the chain, even an out-of-range one.
        plan_command(mres_pkg::KIND_CLEAR_ALL, 3'd5, 5'd0, '0,
                     1'b1, mres_pkg::ST_OK,    '0, 6'd0);
        plan_command(mres_pkg::KIND_COUNT,  3'd0, 5'd0, '0,
                     1'b1, mres_pkg::ST_OK,    '0, 6'd0);
        plan_command(mres_pkg::KIND_ADD,    3'd0, 5'd0, 64'h5,
                     1'b1, mres_pkg::ST_OK,    '0, 6'd1);
        plan_command(mres_pkg::KIND_REMOVE, 3'd0, 5'd0, '0,
                     1'b1, mres_pkg::ST_OK,    '0, 6'd0);
        plan_command(mres_pkg::KIND_CLEAR,  3'd0, 5'd0, '0,
                     1'b1, mres_pkg::ST_OK,    '0, 6'd0);
        // Two-slot rings, chain_count saturating at eight: wrap and overwrite.
        plan_register(mres_pkg::CFG_MAX_ELEMENTS, 6'd2);
        plan_register(mres_pkg::CFG_CHAIN_COUNT, 6'd63);
        plan_command(mres_pkg::KIND_ADD,    3'd7, 5'd0, 64'h1,
                     1'b1, mres_pkg::ST_OK,    '0, 6'd1);
        plan_command(mres_pkg::KIND_ADD,    3'd7, 5'd0, 64'h2,
                     1'b1, mres_pkg::ST_OK,    '0, 6'd2);
        plan_command(mres_pkg::KIND_ADD,    3'd7, 5'd0, 64'h3,
                     1'b1, mres_pkg::ST_OK,    '0, 6'd2);
        plan_command(mres_pkg::KIND_READ,   3'd7, 5'd0, '0,
                     1'b0, mres_pkg::ST_OK,    '0, 6'd0);
        // No rings in use: every chain is out of range.
        plan_register(mres_pkg::CFG_CHAIN_COUNT, 6'd0);
        plan_command(mres_pkg::KIND_COUNT,  3'd0, 5'd0, '0,
                     1'b1, mres_pkg::ST_RANGE, '0, 6'd0);
        // Spare indexes change nothing; max_elements of zero acts as one slot.
        plan_register(CFG_SPARE_LO, 6'd63);
        plan_register(CFG_SPARE_HI, 6'd0);
        plan_register(mres_pkg::CFG_MAX_ELEMENTS, 6'd0);
        plan_register(mres_pkg::CFG_CHAIN_COUNT, 6'd8);
        plan_command(mres_pkg::KIND_ADD,    3'd3, 5'd0, 64'hAA,
                     1'b1, mres_pkg::ST_OK,    '0, 6'd1);
        plan_command(mres_pkg::KIND_ADD,    3'd3, 5'd0, 64'hBB,
                     1'b1, mres_pkg::ST_OK,    '0, 6'd1);
        plan_command(mres_pkg::KIND_READ,   3'd3, 5'd17, '0,
                     1'b0, mres_pkg::ST_OK,    '0, 6'd0);

        // Walk the plan; register rows wait for the block to go idle first.
        gap_style = GAPS_SHORT;
        foreach (test_plan[i])
        begin
            if (test_plan[i].is_reg)
            begin
                quiesce();
                write_register(test_plan[i].reg_index, test_plan[i].reg_value);
            end
            else
                issue_command(test_plan[i].cmd_kind, test_plan[i].cmd_chain,
                              test_plan[i].cmd_pos, test_plan[i].cmd_data,
                              test_plan[i].typed, test_plan[i].want);
        end
        settings_run += 4;

        // Random phases: extremes first, then a couple of arbitrary settings.
        run_phase(6'd32, 6'd1,  PHASE_ITEMS, GAPS_MIXED);
        run_phase(6'd1,  6'd8,  PHASE_ITEMS, GAPS_NONE);
        run_phase(6'd63, 6'd15, PHASE_ITEMS, GAPS_MIXED);
        run_phase(6'd0,  6'd2,  PHASE_ITEMS, GAPS_SHORT);
        run_phase(6'd5,  6'd3,  PHASE_ITEMS, GAPS_MIXED);
        run_phase(6'd20, 6'd8,  PHASE_ITEMS, GAPS_NONE);
        run_phase(6'd2,  6'd0,  30,          GAPS_SHORT);
        run_phase(mres_pkg::MAXEL_W'($urandom_range(63)),
                  mres_pkg::MAXEL_W'($urandom_range(15)), PHASE_ITEMS, GAPS_MIXED);
        run_phase(mres_pkg::MAXEL_W'($urandom_range(1, 8)),
                  mres_pkg::MAXEL_W'($urandom_range(1, 8)), PHASE_ITEMS, GAPS_MIXED);

        // Drain everything still in flight before judging the run.
        quiesce();

        $display("Ran %0d commands over %0d register settings, %0d results checked",
                 commands_run, settings_run, results_seen);
        $display("  add %0d remove %0d clear %0d clear-all %0d update %0d read %0d count %0d",
                 kind_tally[0], kind_tally[1], kind_tally[2], kind_tally[3],
                 kind_tally[4], kind_tally[5], kind_tally[6] + kind_tally[7]);
        if (mismatches == 0 && awaited_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
